[sv/bde_pkg.sv]
// ----------------------------------------------------------------------------
// bde_pkg
// shared types, codes and reset values for the button debounce event unit
// ----------------------------------------------------------------------------
package bde_pkg;

  // widths of the item and result fields
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned EDGE_W   = 32;
  localparam int unsigned DS_W     = 8;
  localparam int unsigned LPT_W    = 32;

  // stream payload widths, zero padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = OPCODE_W;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = EVENT_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // default width of the press timestamp
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // item opcodes
  localparam logic [OPCODE_W-1:0] OP_POLL      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PIN_EDGE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_RD_LATCH  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RD_PEND   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLR_EDGES = 3'd4;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_CNT_EN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_BACKEND  = 3'd5;

  // register reset values
  localparam logic [DS_W-1:0]  DEBOUNCE_RST  = 8'd5;
  localparam logic [LPT_W-1:0] LONG_TIME_RST = 32'd1000;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                pin_level;
    logic                read_error;
    logic [NOW_W-1:0]    now_time;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic               pressed;
    logic               was_pressed;
    logic               irq_was_pending;
    logic [EDGE_W-1:0]  edge_total;
    logic               status;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

[sv/bde_in_reg.sv]
// ----------------------------------------------------------------------------
// bde_in_reg
// input register holding one accepted item until the core takes it
// ----------------------------------------------------------------------------
module bde_in_reg import bde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[sv/bde_core.sv]
// ----------------------------------------------------------------------------
// bde_core
// config registers, debounce and event state, and the item state update
// ----------------------------------------------------------------------------
module bde_core import bde_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_wr_t cfg_i,
  output result_t res_o
);

  localparam int unsigned CMP_W = (TIME_WIDTH > LPT_W) ? TIME_WIDTH : LPT_W;

  // configuration
  logic             active_low_q, active_low_d;
  logic [DS_W-1:0]  debounce_q, debounce_d;
  logic [LPT_W-1:0] long_time_q, long_time_d;
  logic             events_en_q, events_en_d;
  logic             edge_cnt_en_q, edge_cnt_en_d;
  logic             irq_backend_q, irq_backend_d;

  // state
  logic                  stable_q, stable_d;
  logic [DS_W-1:0]       disagree_q, disagree_d;
  logic                  reported_q, reported_d;
  logic                  tracked_q, tracked_d;
  logic                  long_fired_q, long_fired_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic [EDGE_W-1:0]     edges_q, edges_d;
  logic                  pending_q, pending_d;
  logic                  status_q, status_d;

  logic                  sample;
  logic [DS_W-1:0]       cnt_inc;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] held;
  logic [EVENT_W-1:0]    ev;
  logic                  wp;
  logic                  wpend;

  assign sample  = item_i.pin_level ^ active_low_q;
  assign cnt_inc = disagree_q + DS_W'(1);
  assign now_t   = TIME_WIDTH'(item_i.now_time);

  always_comb begin
    active_low_d  = active_low_q;
    debounce_d    = debounce_q;
    long_time_d   = long_time_q;
    events_en_d   = events_en_q;
    edge_cnt_en_d = edge_cnt_en_q;
    irq_backend_d = irq_backend_q;
    stable_d      = stable_q;
    disagree_d    = disagree_q;
    reported_d    = reported_q;
    tracked_d     = tracked_q;
    long_fired_d  = long_fired_q;
    start_d       = start_q;
    edges_d       = edges_q;
    pending_d     = pending_q;
    status_d      = status_q;
    held          = '0;
    ev            = EV_NONE;
    wp            = 1'b0;
    wpend         = 1'b0;

    if (fire_i) begin
      case (item_i.opcode)
        OP_POLL: begin
          if (item_i.read_error) begin
            status_d = 1'b1;
          end else begin
            status_d = 1'b0;
            // debounce: count consecutive samples off the stable level
            if (sample == stable_q) begin
              disagree_d = '0;
            end else if (cnt_inc >= debounce_q) begin
              stable_d   = sample;
              disagree_d = '0;
            end else begin
              disagree_d = cnt_inc;
            end
            // edge of the stable level wins over the long-press check
            held = now_t - start_q;
            if (events_en_q && (stable_d != tracked_q)) begin
              tracked_d    = stable_d;
              long_fired_d = 1'b0;
              if (stable_d) begin
                start_d = now_t;
                ev      = EV_PRESS;
              end else begin
                ev = EV_RELEASE;
              end
            end else if (events_en_q && stable_d && !long_fired_q) begin
              if (CMP_W'(held) >= CMP_W'(long_time_q)) begin
                long_fired_d = 1'b1;
                ev           = EV_LONG;
              end
            end
          end
        end
        OP_PIN_EDGE: begin
          if (edge_cnt_en_q) begin
            edges_d = edges_q + EDGE_W'(1);
          end
          if (irq_backend_q) begin
            pending_d = 1'b1;
          end
        end
        OP_RD_LATCH: begin
          wp         = stable_q && !reported_q;
          reported_d = stable_q;
        end
        OP_RD_PEND: begin
          wpend     = pending_q;
          pending_d = 1'b0;
        end
        OP_CLR_EDGES: begin
          edges_d = '0;
        end
        default: begin
        end
      endcase
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        CFG_ACTIVE_LOW:  active_low_d = cfg_i.data[0];
        CFG_DEBOUNCE: begin
          debounce_d = cfg_i.data[DS_W-1:0];
          disagree_d = '0;
        end
        CFG_LONG_TIME:   long_time_d = cfg_i.data[LPT_W-1:0];
        CFG_EVENTS_EN: begin
          events_en_d  = cfg_i.data[0];
          tracked_d    = stable_q;
          long_fired_d = 1'b0;
        end
        CFG_EDGE_CNT_EN: edge_cnt_en_d = cfg_i.data[0];
        CFG_IRQ_BACKEND: irq_backend_d = cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q  <= 1'b0;
      debounce_q    <= DEBOUNCE_RST;
      long_time_q   <= LONG_TIME_RST;
      events_en_q   <= 1'b0;
      edge_cnt_en_q <= 1'b0;
      irq_backend_q <= 1'b0;
      stable_q      <= 1'b0;
      disagree_q    <= '0;
      reported_q    <= 1'b0;
      tracked_q     <= 1'b0;
      long_fired_q  <= 1'b0;
      start_q       <= '0;
      edges_q       <= '0;
      pending_q     <= 1'b0;
      status_q      <= 1'b0;
    end else begin
      active_low_q  <= active_low_d;
      debounce_q    <= debounce_d;
      long_time_q   <= long_time_d;
      events_en_q   <= events_en_d;
      edge_cnt_en_q <= edge_cnt_en_d;
      irq_backend_q <= irq_backend_d;
      stable_q      <= stable_d;
      disagree_q    <= disagree_d;
      reported_q    <= reported_d;
      tracked_q     <= tracked_d;
      long_fired_q  <= long_fired_d;
      start_q       <= start_d;
      edges_q       <= edges_d;
      pending_q     <= pending_d;
      status_q      <= status_d;
    end
  end

  always_comb begin
    res_o.event_res       = ev;
    res_o.pressed         = stable_d;
    res_o.was_pressed     = wp;
    res_o.irq_was_pending = wpend;
    res_o.edge_total      = edges_d;
    res_o.status          = status_d;
  end

endmodule

[sv/bde_out_reg.sv]
// ----------------------------------------------------------------------------
// bde_out_reg
// result register between the core and the output stream
// ----------------------------------------------------------------------------
module bde_out_reg import bde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[sv/button_debounce_event_unit.sv]
// ----------------------------------------------------------------------------
// button_debounce_event_unit
// counter debounce of a button with press, release and long-press events
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tuser: opcode; tdata: raw, read error, time
//  m_axis    | out       | tuser: event; tdata: levels, edge count, status
//  cfg       | in        | cfg_index_i register index, cfg_data_i value
//
//  one item per cycle sustained while m_axis is not stalled; an item waits in the input
//  register and appears on m_axis the cycle after the core updates state
//  when unstalled, m_axis valid rises once the item has passed the input and result registers
//  all state sits in the core and is updated by the item leaving the input
//  register, so the next item sees it in the very next cycle
//  a stalled m_axis holds the result; s_axis keeps accepting until the
//  input register is also full
//  reset clears all state and loads the register defaults, no clearing pass
//  cfg is taken whenever the input register is empty
//
module button_debounce_event_unit import bde_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] pin_level, [1] read_error, [33:2] now_time, [39:34] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] opcode
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] pressed, [1] was_pressed, [2] irq_was_pending, [34:3] edge_total,
  // [35] status, [39:36] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] event_res
  output logic [M_TUSER_W-1:0]  m_axis_tuser,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    out_free;
  logic    advance;
  cfg_wr_t cfg_wr;
  result_t core_res;
  result_t out_res;

  // unpack the input transfer
  always_comb begin
    in_item.opcode     = s_axis_tuser[OPCODE_W-1:0];
    in_item.pin_level  = s_axis_tdata[0];
    in_item.read_error = s_axis_tdata[1];
    in_item.now_time   = s_axis_tdata[NOW_W+1:2];
  end

  // core fires when an item is waiting and the result register can take it
  assign advance = cur_valid && out_free;

  // register writes only between items so they never race an update
  assign cfg_ready_o  = !cur_valid;
  assign cfg_wr.we    = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  bde_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (advance),
    .item_valid_o (cur_valid),
    .item_o       (cur_item)
  );

  bde_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (cur_item),
    .cfg_i  (cfg_wr),
    .res_o  (core_res)
  );

  bde_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // pack the result transfer
  assign m_axis_tuser = out_res.event_res;
  assign m_axis_tdata = {
    {(M_TDATA_W - EDGE_W - 4){1'b0}},
    out_res.status,
    out_res.edge_total,
    out_res.irq_was_pending,
    out_res.was_pressed,
    out_res.pressed
  };

endmodule

[sv/bde_checker.sv]
// ----------------------------------------------------------------------------
// bde_checker
// port-level checks on the result stream of the button debounce event unit
// ----------------------------------------------------------------------------
module bde_checker import bde_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // latch read reports pressed only while the button is pressed
  a_latch_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("was_pressed without pressed");

  // press and long press come with a pressed level, release without
  a_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_NONE) |->
      (m_axis_tdata[0] == (m_axis_tuser != EV_RELEASE)))
    else $error("event does not match pressed level");

  // events only from good polls
  a_event_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_NONE) |->
      !m_axis_tdata[EDGE_W+3] && !m_axis_tdata[1] && !m_axis_tdata[2])
    else $error("event alongside read error or read-clear");

endmodule

bind button_debounce_event_unit bde_checker u_bde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
